@@ rtl/memory_region_protection_check_defines.svh @@
// ----------------------------------------------------------------------------
// memory region protection check: assertion macros
// shared assertion wrappers, compiled out when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef MEMORY_REGION_PROTECTION_CHECK_DEFINES_SVH
`define MEMORY_REGION_PROTECTION_CHECK_DEFINES_SVH

`ifndef SYNTHESIS

// property that holds in the same cycle
`define MRPC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mrpc assertion failed");

// antecedent implies consequent in the following cycle
`define MRPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mrpc assertion failed");

`else

`define MRPC_ASSERT(label, clk, rst_n, prop)
`define MRPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/mrpc_pkg.sv @@
// ----------------------------------------------------------------------------
// mrpc_pkg
// types and constants shared by the region check chain and its cells
// ----------------------------------------------------------------------------
package mrpc_pkg;

    // region flag layout
    localparam int FLAGS_WIDTH = 5;
    localparam int FLAG_R      = 0;
    localparam int FLAG_W      = 1;
    localparam int FLAG_X      = 2;
    localparam int FLAG_L      = 3;
    localparam int FLAG_V      = 4;

    // check token handed from cell to cell
    typedef struct packed {
        logic active;
        logic enforce;
        logic x_done;
        logic x;
        logic d_done;
        logic r;
        logic w;
    } tok_t;

endpackage

@@ rtl/mrpc_cell.sv @@
// ----------------------------------------------------------------------------
// mrpc_cell
// one region entry: holds the range and flags, updates the passing token
// ----------------------------------------------------------------------------
module mrpc_cell #(
    parameter int ADDR_WIDTH = 48
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mrpc_pkg::tok_t                   tok_in,
    output mrpc_pkg::tok_t                   tok_out,
    input  logic [ADDR_WIDTH-1:0]            fetch_addr,
    input  logic [ADDR_WIDTH-1:0]            data_addr,
    input  logic                             wr_en,
    input  logic [ADDR_WIDTH-1:0]            wr_start,
    input  logic [ADDR_WIDTH-1:0]            wr_end,
    input  logic [mrpc_pkg::FLAGS_WIDTH-1:0] wr_flags
);

    logic [ADDR_WIDTH-1:0]            start_reg;
    logic [ADDR_WIDTH-1:0]            start_next;
    logic [ADDR_WIDTH-1:0]            end_reg;
    logic [ADDR_WIDTH-1:0]            end_next;
    logic [mrpc_pkg::FLAGS_WIDTH-1:0] flags_reg;
    logic [mrpc_pkg::FLAGS_WIDTH-1:0] flags_next;
    mrpc_pkg::tok_t                   tok_reg;
    mrpc_pkg::tok_t                   tok_next;
    logic                             usable;
    logic                             apply_f;
    logic                             apply_d;

    // entry update, invalid regions keep a zero range
    always_comb
    begin
        start_next = start_reg;
        end_next   = end_reg;
        flags_next = flags_reg;
        if (wr_en)
        begin
            start_next = wr_flags[mrpc_pkg::FLAG_V] ? wr_start : '0;
            end_next   = wr_flags[mrpc_pkg::FLAG_V] ? wr_end : '0;
            flags_next = wr_flags;
        end
    end

    // first applying entry along the chain decides
    always_comb
    begin
        usable  = flags_reg[mrpc_pkg::FLAG_V]
                  && (tok_in.enforce || flags_reg[mrpc_pkg::FLAG_L]);
        apply_f = usable && (fetch_addr >= start_reg) && (fetch_addr <= end_reg);
        apply_d = usable && (data_addr >= start_reg) && (data_addr <= end_reg);
        tok_next = tok_in;
        if (!tok_in.x_done && apply_f)
        begin
            tok_next.x_done = 1'b1;
            tok_next.x      = flags_reg[mrpc_pkg::FLAG_X];
        end
        if (!tok_in.d_done && apply_d)
        begin
            tok_next.d_done = 1'b1;
            tok_next.r      = flags_reg[mrpc_pkg::FLAG_R];
            tok_next.w      = flags_reg[mrpc_pkg::FLAG_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            end_reg   <= '0;
            flags_reg <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            start_reg <= start_next;
            end_reg   <= end_next;
            flags_reg <= flags_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

@@ rtl/memory_region_protection_check.sv @@
// ----------------------------------------------------------------------------
// memory_region_protection_check
// range based region protection check for one fetch and one data address
//
// a request is taken at a clock edge with start high and busy low. it carries
// the two addresses, the enforce flag and an optional region table write.
// a check token walks a row of ENTRIES cells, one cell per cycle, each cell
// holding one region; the lowest applying region sets the permissions.
// done rises as the token leaves the last cell's register and holds
// read_allowed, write_allowed, exec_allowed for one cycle. the receiver cannot stall.
// busy stays high until the token enters the last cell, so a new request is
// never taken while another walks the row; the walk sets the request rate.
// the table write of a request lands when the token reaches the last cell,
// so the check always sees the table as it stood before the request.
// writes to entry_index >= ENTRIES are dropped.
// reset clears the region table and drops any request in flight.
// ----------------------------------------------------------------------------
`include "memory_region_protection_check_defines.svh"

module memory_region_protection_check #(
    parameter int ENTRIES    = 8,
    parameter int ADDR_WIDTH = 48
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             enforce,
    input  logic [ADDR_WIDTH-1:0]            fetch_addr,
    input  logic [ADDR_WIDTH-1:0]            data_addr,
    input  logic                             write_entry,
    input  logic [2:0]                       entry_index,
    input  logic [ADDR_WIDTH-1:0]            new_start,
    input  logic [ADDR_WIDTH-1:0]            new_end,
    input  logic [mrpc_pkg::FLAGS_WIDTH-1:0] new_flags,
    output logic                             done,
    output logic                             read_allowed,
    output logic                             write_allowed,
    output logic                             exec_allowed
);

    // request accepted this edge
    logic accept;

    // control
    logic busy_reg;
    logic busy_next;
    logic wr_pend_reg;
    logic wr_pend_next;
    mrpc_pkg::tok_t launch_reg;
    mrpc_pkg::tok_t launch_next;

    // request payload, held while the token walks
    logic [ADDR_WIDTH-1:0]            fetch_reg;
    logic [ADDR_WIDTH-1:0]            fetch_next;
    logic [ADDR_WIDTH-1:0]            data_reg;
    logic [ADDR_WIDTH-1:0]            data_next;
    logic [2:0]                       wr_idx_reg;
    logic [2:0]                       wr_idx_next;
    logic [ADDR_WIDTH-1:0]            wr_start_reg;
    logic [ADDR_WIDTH-1:0]            wr_start_next;
    logic [ADDR_WIDTH-1:0]            wr_end_reg;
    logic [ADDR_WIDTH-1:0]            wr_end_next;
    logic [mrpc_pkg::FLAGS_WIDTH-1:0] wr_flags_reg;
    logic [mrpc_pkg::FLAGS_WIDTH-1:0] wr_flags_next;

    // token at each point of the row: 0 is the launch slot, i+1 leaves cell i
    mrpc_pkg::tok_t     tok [ENTRIES+1];
    logic [ENTRIES:0]   tok_act;
    logic               wr_fire;

    assign accept = start && !busy_reg;

    // the table write lands as the token enters the last cell
    assign wr_fire = tok[ENTRIES-1].active && wr_pend_reg;

    always_comb
    begin
        busy_next    = busy_reg;
        wr_pend_next = wr_pend_reg;
        launch_next  = launch_reg;
        launch_next.active = 1'b0;
        if (tok[ENTRIES-1].active)
        begin
            busy_next    = 1'b0;
            wr_pend_next = 1'b0;
        end
        if (accept)
        begin
            busy_next           = 1'b1;
            wr_pend_next        = write_entry;
            // start from the no-match default
            launch_next.active  = 1'b1;
            launch_next.enforce = enforce;
            launch_next.x_done  = 1'b0;
            launch_next.d_done  = 1'b0;
            launch_next.x       = !enforce;
            launch_next.r       = !enforce;
            launch_next.w       = !enforce;
        end
    end

    always_comb
    begin
        fetch_next    = fetch_reg;
        data_next     = data_reg;
        wr_idx_next   = wr_idx_reg;
        wr_start_next = wr_start_reg;
        wr_end_next   = wr_end_reg;
        wr_flags_next = wr_flags_reg;
        if (accept)
        begin
            fetch_next    = fetch_addr;
            data_next     = data_addr;
            wr_idx_next   = entry_index;
            wr_start_next = new_start;
            wr_end_next   = new_end;
            wr_flags_next = new_flags;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            wr_pend_reg <= 1'b0;
            launch_reg  <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            wr_pend_reg <= wr_pend_next;
            launch_reg  <= launch_next;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        fetch_reg    <= fetch_next;
        data_reg     <= data_next;
        wr_idx_reg   <= wr_idx_next;
        wr_start_reg <= wr_start_next;
        wr_end_reg   <= wr_end_next;
        wr_flags_reg <= wr_flags_next;
    end

    assign tok[0]     = launch_reg;
    assign tok_act[0] = tok[0].active;

    // row of region cells, token moves one cell per cycle
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        logic sel;

        // indexes past the table never match
        assign sel = wr_fire && (int'(wr_idx_reg) == i);

        mrpc_cell #(
            .ADDR_WIDTH (ADDR_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .tok_in     (tok[i]),
            .tok_out    (tok[i+1]),
            .fetch_addr (fetch_reg),
            .data_addr  (data_reg),
            .wr_en      (sel),
            .wr_start   (wr_start_reg),
            .wr_end     (wr_end_reg),
            .wr_flags   (wr_flags_reg)
        );

        assign tok_act[i+1] = tok[i+1].active;
    end

    // result straight from the last cell's register
    assign busy          = busy_reg;
    assign done          = tok[ENTRIES].active;
    assign read_allowed  = tok[ENTRIES].r;
    assign write_allowed = tok[ENTRIES].w;
    assign exec_allowed  = tok[ENTRIES].x;

    // a taken request marks the block busy
    `MRPC_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)
    // at most one request walks the row
    `MRPC_ASSERT(a_one_token, clk, rst_n, $onehot0(tok_act))
    // the result stage is only reached once busy has dropped
    `MRPC_ASSERT(a_idle_empty, clk, rst_n, !busy || tok_act[ENTRIES] == 1'b0)
    // one result pulse per request
    `MRPC_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)

endmodule

@@ test/memory_region_protection_check_test.sv @@
// ----------------------------------------------------------------------------
// memory_region_protection_check_test
// self-checking bench for the range based region protection check
//
// requests go in through start/busy and each one carries a fetch address,
// a data address, the enforce flag and an optional region table write. a
// behavioral copy of the region table predicts read/write/exec permissions
// for every accepted request, and each done strobe is matched against the
// oldest prediction. directed tests cover reset defaults, range edges, the
// largest address, invalid and empty regions, priority and the rule that a
// request is checked against the table as it stood before its own write.
// a long random phase then aims addresses at the edges of the live regions.
// ----------------------------------------------------------------------------
module memory_region_protection_check_test;

    localparam int TABLE_SIZE      = 8;
    localparam int ADDR_W          = 48;
    localparam int FLAGS_W         = mrpc_pkg::FLAGS_WIDTH;
    localparam int STALL_LIMIT     = 200;
    localparam int RANDOM_REQUESTS = 1380;
    localparam int SHOWN_ERRORS    = 10;

    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

    // single flag masks, built from the package bit positions
    localparam logic [FLAGS_W-1:0] PERM_R = FLAGS_W'(1 << mrpc_pkg::FLAG_R);
    localparam logic [FLAGS_W-1:0] PERM_W = FLAGS_W'(1 << mrpc_pkg::FLAG_W);
    localparam logic [FLAGS_W-1:0] PERM_X = FLAGS_W'(1 << mrpc_pkg::FLAG_X);
    localparam logic [FLAGS_W-1:0] LOCKED = FLAGS_W'(1 << mrpc_pkg::FLAG_L);
    localparam logic [FLAGS_W-1:0] VALID  = FLAGS_W'(1 << mrpc_pkg::FLAG_V);

    // one request as it goes into the block
    typedef struct packed {
        logic                   enforce;
        logic [ADDR_W-1:0]      fetch_addr;
        logic [ADDR_W-1:0]      data_addr;
        logic                   write_entry;
        logic [2:0]             entry_index;
        logic [ADDR_W-1:0]      new_start;
        logic [ADDR_W-1:0]      new_end;
        logic [FLAGS_W-1:0]     new_flags;
    } request_t;

    // one permission result
    typedef struct packed {
        logic read;
        logic write;
        logic exec;
    } perm_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic                   enforce;
    logic [ADDR_W-1:0]      fetch_addr;
    logic [ADDR_W-1:0]      data_addr;
    logic                   write_entry;
    logic [2:0]             entry_index;
    logic [ADDR_W-1:0]      new_start;
    logic [ADDR_W-1:0]      new_end;
    logic [FLAGS_W-1:0]     new_flags;
    logic                   done;
    logic                   read_allowed;
    logic                   write_allowed;
    logic                   exec_allowed;

    // behavioral region table, updated as requests are accepted
    logic [ADDR_W-1:0]      table_lo [TABLE_SIZE];
    logic [ADDR_W-1:0]      table_hi [TABLE_SIZE];
    logic [FLAGS_W-1:0]     table_flags [TABLE_SIZE];

    // permissions still owed by the block, oldest first
    perm_t pending_perms [$];

    int  mismatches;
    int  requests_accepted;
    int  writes_accepted;
    int  results_checked;
    int  denied_results;
    int  idle_cycles;
    bit  back_to_back;

    memory_region_protection_check #(
        .ENTRIES    (TABLE_SIZE),
        .ADDR_WIDTH (ADDR_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .enforce       (enforce),
        .fetch_addr    (fetch_addr),
        .data_addr     (data_addr),
        .write_entry   (write_entry),
        .entry_index   (entry_index),
        .new_start     (new_start),
        .new_end       (new_end),
        .new_flags     (new_flags),
        .done          (done),
        .read_allowed  (read_allowed),
        .write_allowed (write_allowed),
        .exec_allowed  (exec_allowed)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // permission predictor
    // ------------------------------------------------------------------------

    // region i covers addr and takes part in the check
    function automatic bit region_hits(int i, logic [ADDR_W-1:0] addr, logic enf);
        if (addr < table_lo[i] || addr > table_hi[i])
            return 1'b0;
        return table_flags[i][mrpc_pkg::FLAG_V] && (enf || table_flags[i][mrpc_pkg::FLAG_L]);
    endfunction

    // permissions for one request, then apply its table write
    function automatic perm_t predict_permissions(request_t req);
        perm_t p;
        bit    fetch_found;
        bit    data_found;
        bit    valid_write;

        // nothing hitting: open when not enforcing, closed when enforcing
        p.read  = !req.enforce;
        p.write = !req.enforce;
        p.exec  = !req.enforce;
        fetch_found = 1'b0;
        data_found  = 1'b0;

        // lowest index hit wins, separately for each address
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            if (!fetch_found && region_hits(i, req.fetch_addr, req.enforce))
            begin
                p.exec      = table_flags[i][mrpc_pkg::FLAG_X];
                fetch_found = 1'b1;
            end
            if (!data_found && region_hits(i, req.data_addr, req.enforce))
            begin
                p.read     = table_flags[i][mrpc_pkg::FLAG_R];
                p.write    = table_flags[i][mrpc_pkg::FLAG_W];
                data_found = 1'b1;
            end
        end

        // write lands after the check; an invalid region keeps zero bounds
        valid_write = req.new_flags[mrpc_pkg::FLAG_V];
        if (req.write_entry && int'(req.entry_index) < TABLE_SIZE)
        begin
            table_lo[req.entry_index]    = valid_write ? req.new_start : '0;
            table_hi[req.entry_index]    = valid_write ? req.new_end : '0;
            table_flags[req.entry_index] = req.new_flags;
        end
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // request construction and address pickers
    // ------------------------------------------------------------------------

    // check only, no table write
    function automatic request_t probe(logic enf, logic [ADDR_W-1:0] f,
                                       logic [ADDR_W-1:0] d);
        request_t req;

        req             = '0;
        req.enforce     = enf;
        req.fetch_addr  = f;
        req.data_addr   = d;
        return req;
    endfunction

    // check plus a table write
    function automatic request_t probe_w(logic enf, logic [ADDR_W-1:0] f,
                                         logic [ADDR_W-1:0] d, logic [2:0] idx,
                                         logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi,
                                         logic [FLAGS_W-1:0] flags);
        request_t req;

        req             = probe(enf, f, d);
        req.write_entry = 1'b1;
        req.entry_index = idx;
        req.new_start   = lo;
        req.new_end     = hi;
        req.new_flags   = flags;
        return req;
    endfunction

    function automatic logic [ADDR_W-1:0] wide_random();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    // a few address neighborhoods so regions overlap often, one at the top
    function automatic logic [ADDR_W-1:0] window_base();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return ADDR_W'(48'h0000_1000_0000);
            default: return ADDR_MAX - ADDR_W'(48'h1fff);
        endcase
    endfunction

    // edges of table regions, points inside them, window addresses or anywhere
    function automatic logic [ADDR_W-1:0] pick_address();
        int                e;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;

        e  = $urandom_range(0, TABLE_SIZE - 1);
        lo = table_lo[e];
        hi = table_hi[e];
        case ($urandom_range(0, 9))
            0:       return lo - 1'b1;
            1:       return lo;
            2:       return hi;
            3:       return hi + 1'b1;
            4, 5:
            begin
                if (hi >= lo && (hi - lo) != ADDR_MAX)
                    return lo + wide_random() % (hi - lo + 1'b1);
                return wide_random();
            end
            6, 7:    return window_base() + ADDR_W'($urandom_range(0, 8191));
            default: return wide_random();
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // request driver: called and returns at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_request(request_t req);
        int gap;

        gap = back_to_back ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
            // now and then let the block drain fully before the next request
            if ($urandom_range(0, 2) == 0)
            begin
                do @(posedge clk); while (busy);
                @(negedge clk);
                repeat ($urandom_range(0, 8)) @(negedge clk);
            end
        end

        // start stays high across back-to-back requests
        start       <= 1'b1;
        enforce     <= req.enforce;
        fetch_addr  <= req.fetch_addr;
        data_addr   <= req.data_addr;
        write_entry <= req.write_entry;
        entry_index <= req.entry_index;
        new_start   <= req.new_start;
        new_end     <= req.new_end;
        new_flags   <= req.new_flags;

        // taken at the first rising edge with busy low
        do @(posedge clk); while (busy);
        pending_perms.push_back(predict_permissions(req));
        requests_accepted++;
        if (req.write_entry)
            writes_accepted++;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    task automatic note_mismatch(string what, logic [2:0] want, logic [2:0] got);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
            $display("%0t: %s mismatch, expected %b, got %b", $realtime, what, want, got);
    endtask

    always @(posedge clk)
    begin : check_results
        perm_t want;

        if (rst_n && done)
        begin
            if (pending_perms.size() == 0)
                note_mismatch("unexpected result", 3'b000,
                              {read_allowed, write_allowed, exec_allowed});
            else
            begin
                want = pending_perms.pop_front();
                results_checked++;
                if (!(read_allowed && write_allowed && exec_allowed))
                    denied_results++;
                if (read_allowed !== want.read)
                    note_mismatch("read_allowed", 3'(want.read), 3'(read_allowed));
                if (write_allowed !== want.write)
                    note_mismatch("write_allowed", 3'(want.write), 3'(write_allowed));
                if (exec_allowed !== want.exec)
                    note_mismatch("exec_allowed", 3'(want.exec), 3'(exec_allowed));
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: no request taken and no result for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles = 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", idle_cycles);
            $display("memory_region_protection_check_test: done, errors");
            $finish;
        end
        else
            idle_cycles++;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // cleared table: everything open without enforce, closed with it
    task automatic test_reset_defaults();
        send_request(probe(1'b0, ADDR_MAX, ADDR_MAX));
        send_request(probe(1'b1, '0, '0));
    endtask

    // inclusive edges, the top address and a region covering everything
    task automatic test_region_boundaries();
        // locked read/exec region, checked with enforce off
        send_request(probe_w(1'b0, 'h1000, 'h1000, 3'd0, 'h1000, 'h1fff,
                             VALID | LOCKED | PERM_R | PERM_X));
        send_request(probe(1'b0, 'h0fff, 'h1000));
        send_request(probe(1'b0, 'h1fff, 'h2000));
        send_request(probe(1'b0, 'h1000, 'h1fff));
        // unlocked single top address in the last entry
        send_request(probe_w(1'b1, ADDR_MAX, ADDR_MAX, 3'd7, ADDR_MAX, ADDR_MAX,
                             VALID | PERM_W));
        send_request(probe(1'b1, ADDR_MAX, ADDR_MAX));
        send_request(probe(1'b0, ADDR_MAX, ADDR_MAX));
        // locked region over the whole address space
        send_request(probe_w(1'b1, 'h500, 'h500, 3'd6, '0, ADDR_MAX,
                             VALID | LOCKED | PERM_X));
        send_request(probe(1'b1, '0, 'h1800));
    endtask

    // invalid region keeps zero bounds, start above end matches nothing
    task automatic test_invalid_and_empty();
        send_request(probe_w(1'b1, 'h4800, '0, 3'd1, 'h4000, 'h4fff,
                             LOCKED | PERM_R | PERM_W | PERM_X));
        send_request(probe(1'b1, 'h4800, '0));
        send_request(probe_w(1'b1, 'h9000, 'h8800, 3'd2, 'h9000, 'h8000,
                             VALID | LOCKED | PERM_R | PERM_W | PERM_X));
        send_request(probe(1'b1, 'h9000, 'h8800));
        send_request(probe_w(1'b1, 'h8000, 'h8000, 3'd3, 'h8000, 'h8000,
                             VALID | LOCKED | PERM_R));
        send_request(probe(1'b1, 'h7fff, 'h8000));
    endtask

    // lower index wins; a write never affects its own check
    task automatic test_priority_and_write_order();
        send_request(probe_w(1'b0, 'h2800, 'h1800, 3'd4, 'h1800, 'h2800,
                             VALID | LOCKED | PERM_R | PERM_W | PERM_X));
        send_request(probe(1'b0, 'h2800, 'h2000));
        // drop entry 0 while checking inside it
        send_request(probe_w(1'b0, 'h1800, 'h1800, 3'd0, 'h1800, 'h1800, '0));
        send_request(probe(1'b0, 'h1800, 'h1800));
        // unlocked region only counts under enforce
        send_request(probe_w(1'b1, 'h150, 'h150, 3'd5, 'h100, 'h1ff, VALID | PERM_R));
        send_request(probe(1'b1, 'h150, 'h150));
        send_request(probe(1'b0, 'h150, 'h150));
    endtask

    // random regions and addresses aimed at their edges
    task automatic test_random_traffic();
        request_t          req;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            // stretches with no gaps at all between requests
            if (n % 64 == 0)
                back_to_back = ($urandom_range(0, 3) == 0);

            req.enforce     = 1'($urandom_range(0, 1));
            req.fetch_addr  = pick_address();
            req.data_addr   = pick_address();
            req.write_entry = ($urandom_range(0, 9) < 3);
            req.entry_index = 3'($urandom_range(0, TABLE_SIZE - 1));
            req.new_flags   = FLAGS_W'($urandom_range(0, 31));
            if ($urandom_range(0, 3) != 0)
                req.new_flags[mrpc_pkg::FLAG_V] = 1'b1;

            case ($urandom_range(0, 9))
                0:
                begin
                    lo = wide_random();
                    hi = wide_random();
                end
                1:
                begin
                    lo = '0;
                    hi = ADDR_MAX;
                end
                2:
                begin
                    // start above end
                    hi = window_base() + ADDR_W'($urandom_range(0, 4095));
                    lo = hi + ADDR_W'($urandom_range(1, 64));
                end
                default:
                begin
                    lo = window_base() + ADDR_W'($urandom_range(0, 4095));
                    hi = lo + ADDR_W'($urandom_range(0, 511));
                end
            endcase
            req.new_start = lo;
            req.new_end   = hi;
            send_request(req);
        end
        back_to_back = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        enforce      = 1'b0;
        fetch_addr   = '0;
        data_addr    = '0;
        write_entry  = 1'b0;
        entry_index  = '0;
        new_start    = '0;
        new_end      = '0;
        new_flags    = '0;
        mismatches   = 0;
        idle_cycles  = 0;
        back_to_back = 1'b0;
        requests_accepted = 0;
        writes_accepted   = 0;
        results_checked   = 0;
        denied_results    = 0;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            table_lo[i]    = '0;
            table_hi[i]    = '0;
            table_flags[i] = '0;
        end

        // reset held, then released away from the rising edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_region_boundaries();
        test_invalid_and_empty();
        test_priority_and_write_order();
        test_random_traffic();

        // drain: the watchdog bounds this wait
        start <= 1'b0;
        while (pending_perms.size() != 0)
            @(posedge clk);
        repeat (TABLE_SIZE + 4) @(posedge clk);

        $display("%0d requests sent, %0d of them with a region write",
                 requests_accepted, writes_accepted);
        $display("%0d results checked, %0d with some access denied, %0d mismatches",
                 results_checked, denied_results, mismatches);
        if (mismatches == 0)
            $display("memory_region_protection_check_test: done, clean");
        else
            $display("memory_region_protection_check_test: done, errors");
        $finish;
    end

endmodule
